// ===== src/ubcd_pkg.sv =====
// Package for the up/down BCD counter display: widths, register codes,
// mode and phase types, config bundle and the seven-segment decode.
// No dependencies.
package ubcd_pkg;

  // Width of dwell and blank tick counts.
  localparam int unsigned DWELL_BITS = 10;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned BLINK_W    = 8;
  localparam int unsigned SEG_W      = 7;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = (DWELL_BITS > BLINK_W) ? DWELL_BITS : BLINK_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(99);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT_TOP     = 4'd0,
    CFG_UP_DWELL      = 4'd1,
    CFG_DOWN_DWELL    = 4'd2,
    CFG_UP_BLINKS     = 4'd3,
    CFG_DOWN_BLINKS   = 4'd4,
    CFG_UP_BLANK      = 4'd5,
    CFG_DOWN_BLANK    = 4'd6,
    CFG_UP_TAIL_BLANK = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_UP        = 2'd0,
    MODE_DOWN      = 2'd1,
    MODE_HALT_TOP  = 2'd2,
    MODE_HALT_ZERO = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_LIT   = 2'd0,
    PH_BLANK = 2'd1,
    PH_TAIL  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CNT_W-1:0]      count_top;
    logic [DWELL_BITS-1:0] up_dwell;
    logic [DWELL_BITS-1:0] down_dwell;
    logic [BLINK_W-1:0]    up_blinks;
    logic [BLINK_W-1:0]    down_blinks;
    logic [DWELL_BITS-1:0] up_blank;
    logic [DWELL_BITS-1:0] down_blank;
    logic [DWELL_BITS-1:0] up_tail_blank;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    count_top:     CNT_W'(59),
    up_dwell:      DWELL_BITS'(20),
    down_dwell:    DWELL_BITS'(50),
    up_blinks:     BLINK_W'(11),
    down_blinks:   BLINK_W'(5),
    up_blank:      DWELL_BITS'(20),
    down_blank:    DWELL_BITS'(50),
    up_tail_blank: DWELL_BITS'(20)
  };

  // What the sequencer reports for the tick being processed.
  typedef struct packed {
    logic             lit;
    logic [CNT_W-1:0] count;
    mode_e            mode;
  } view_t;

  // Seven-segment pattern of one decimal digit, bit0 = a.
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0:    seg = 7'h3f;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5b;
      4'd3:    seg = 7'h4f;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6d;
      4'd6:    seg = 7'h7d;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7f;
      4'd9:    seg = 7'h6f;
      default: seg = '0;
    endcase
    return seg;
  endfunction

  // Tens digit of a count up to 99, by parallel compares.
  function automatic logic [3:0] tens_of(input logic [CNT_W-1:0] c);
    logic [3:0] t;
    t = 4'd0;
    for (int unsigned k = 1; k <= 9; k++) begin
      if (c >= CNT_W'(10 * k)) t = 4'(k);
    end
    return t;
  endfunction

endpackage

// ===== src/ubcd_if.sv =====
// Valid/ready channel interfaces for tick items and display result items.
// Depends on ubcd_pkg for field widths.
interface ubcd_in_if;
  logic valid;
  logic ready;
  logic switch_up;

  modport source (output valid, output switch_up, input ready);
  modport sink (input valid, input switch_up, output ready);
endinterface

interface ubcd_out_if;
  logic                                valid;
  logic                                ready;
  logic [ubcd_pkg::SEG_W-1:0]          segments;
  logic                                low_digit_on;
  logic                                high_digit_on;
  logic [ubcd_pkg::CNT_W-1:0]          count_value;
  logic [1:0]                          mode;

  modport source (output valid, output segments, output low_digit_on,
                  output high_digit_on, output count_value, output mode,
                  input ready);
  modport sink (input valid, input segments, input low_digit_on,
                input high_digit_on, input count_value, input mode,
                output ready);
endinterface

// ===== src/ubcd_cfg_regs.sv =====
// Configuration register file of the counter display.
// Depends on ubcd_pkg.
module ubcd_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ubcd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ubcd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output ubcd_pkg::cfg_t                      cfg_o
);

  ubcd_pkg::cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ubcd_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ubcd_pkg::CFG_COUNT_TOP: begin
          cfg_q.count_top <= cfg_data_i[ubcd_pkg::CNT_W-1:0];
        end
        ubcd_pkg::CFG_UP_DWELL: begin
          cfg_q.up_dwell <= cfg_data_i[ubcd_pkg::DWELL_BITS-1:0];
        end
        ubcd_pkg::CFG_DOWN_DWELL: begin
          cfg_q.down_dwell <= cfg_data_i[ubcd_pkg::DWELL_BITS-1:0];
        end
        ubcd_pkg::CFG_UP_BLINKS: begin
          cfg_q.up_blinks <= cfg_data_i[ubcd_pkg::BLINK_W-1:0];
        end
        ubcd_pkg::CFG_DOWN_BLINKS: begin
          cfg_q.down_blinks <= cfg_data_i[ubcd_pkg::BLINK_W-1:0];
        end
        ubcd_pkg::CFG_UP_BLANK: begin
          cfg_q.up_blank <= cfg_data_i[ubcd_pkg::DWELL_BITS-1:0];
        end
        ubcd_pkg::CFG_DOWN_BLANK: begin
          cfg_q.down_blank <= cfg_data_i[ubcd_pkg::DWELL_BITS-1:0];
        end
        ubcd_pkg::CFG_UP_TAIL_BLANK: begin
          cfg_q.up_tail_blank <= cfg_data_i[ubcd_pkg::DWELL_BITS-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ubcd_seq.sv =====
// Period sequencer: mode choice, count update, blink/blank/tail phases.
// Depends on ubcd_pkg.
module ubcd_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           switch_up_i,
  input  ubcd_pkg::cfg_t cfg_i,
  output ubcd_pkg::view_t view_o
);

  typedef struct packed {
    ubcd_pkg::phase_e                    phase;
    logic [ubcd_pkg::DWELL_BITS-1:0]     tick;
    logic [ubcd_pkg::BLINK_W-1:0]        bl;
    logic                                alive;
  } ph_t;

  logic [ubcd_pkg::CNT_W-1:0] count_q, count_d;
  ubcd_pkg::mode_e            mode_q, mode_d;
  logic                       pstart_q, pstart_d;
  ubcd_pkg::phase_e           phase_q, phase_d;
  logic [ubcd_pkg::DWELL_BITS-1:0] tick_q, tick_d;
  logic [ubcd_pkg::BLINK_W-1:0]    bl_q, bl_d;

  // Skip phases of zero length; closed form of the skip loop, since
  // zero dwell plus zero blank just burns all remaining blinks.
  function automatic ph_t settle_f(input ph_t s, input ubcd_pkg::mode_e m,
                                   input ubcd_pkg::cfg_t c);
    ph_t r;
    logic top;
    logic [ubcd_pkg::DWELL_BITS-1:0] dwell, blank, tail;
    logic [ubcd_pkg::BLINK_W-1:0] bl1;
    logic from_blank;
    top   = (m == ubcd_pkg::MODE_HALT_TOP);
    dwell = top ? c.up_dwell : c.down_dwell;
    blank = top ? c.up_blank : c.down_blank;
    tail  = top ? c.up_tail_blank : '0;
    r = s;
    r.alive = 1'b1;
    from_blank = 1'b0;
    bl1 = (s.bl != '0) ? s.bl - 1'b1 : '0;
    if (s.tick != '0) begin
      r.alive = 1'b1;
    end else if (m == ubcd_pkg::MODE_UP || m == ubcd_pkg::MODE_DOWN) begin
      r.alive = 1'b0;
    end else begin
      case (s.phase)
        ubcd_pkg::PH_LIT: begin
          if (blank != '0) begin
            r.phase = ubcd_pkg::PH_BLANK;
            r.tick  = blank;
          end else begin
            from_blank = 1'b1;
          end
        end
        ubcd_pkg::PH_BLANK: begin
          from_blank = 1'b1;
        end
        default: begin
          r.alive = 1'b0;
        end
      endcase
      // Blank spell done: next blink, or tail once blinks run out
      if (from_blank) begin
        if (bl1 != '0 && dwell != '0) begin
          r.phase = ubcd_pkg::PH_LIT;
          r.tick  = dwell;
          r.bl    = bl1;
        end else if (bl1 != '0 && blank != '0) begin
          r.phase = ubcd_pkg::PH_BLANK;
          r.tick  = blank;
          r.bl    = bl1;
        end else begin
          r.phase = ubcd_pkg::PH_TAIL;
          r.tick  = tail;
          r.bl    = '0;
          r.alive = (tail != '0);
        end
      end
    end
    return r;
  endfunction

  logic [ubcd_pkg::CNT_W-1:0] top_lim;
  logic [ubcd_pkg::CNT_W-1:0] count_b;
  ubcd_pkg::mode_e            mode_b;
  ph_t                        beg_s, s0, s1, s2;

  assign top_lim = (cfg_i.count_top > ubcd_pkg::COUNT_MAX) ? ubcd_pkg::COUNT_MAX
                                                            : cfg_i.count_top;

  // Period start: pick a mode from the switch and set up the first phase
  always_comb begin
    count_b      = count_q;
    beg_s.alive  = 1'b1;
    beg_s.bl     = bl_q;
    if (switch_up_i && count_q < top_lim) begin
      mode_b      = ubcd_pkg::MODE_UP;
      count_b     = count_q + 1'b1;
      beg_s.phase = ubcd_pkg::PH_LIT;
      beg_s.tick  = (cfg_i.up_dwell != '0) ? cfg_i.up_dwell
                                           : ubcd_pkg::DWELL_BITS'(1);
    end else if (!switch_up_i && count_q != '0) begin
      mode_b      = ubcd_pkg::MODE_DOWN;
      count_b     = count_q - 1'b1;
      beg_s.phase = ubcd_pkg::PH_LIT;
      beg_s.tick  = (cfg_i.down_dwell != '0) ? cfg_i.down_dwell
                                             : ubcd_pkg::DWELL_BITS'(1);
    end else begin
      mode_b   = switch_up_i ? ubcd_pkg::MODE_HALT_TOP : ubcd_pkg::MODE_HALT_ZERO;
      beg_s.bl = switch_up_i ? cfg_i.up_blinks : cfg_i.down_blinks;
      if (beg_s.bl != '0) begin
        beg_s.phase = ubcd_pkg::PH_LIT;
        beg_s.tick  = switch_up_i ? cfg_i.up_dwell : cfg_i.down_dwell;
      end else begin
        beg_s.phase = ubcd_pkg::PH_TAIL;
        beg_s.tick  = switch_up_i ? cfg_i.up_tail_blank : '0;
      end
    end
  end

  // Tick processing: resolve current phase, consume one tick, settle again
  always_comb begin
    if (pstart_q) begin
      mode_d  = mode_b;
      count_d = count_b;
      s0      = settle_f(beg_s, mode_b, cfg_i);
    end else begin
      mode_d  = mode_q;
      count_d = count_q;
      s0      = '{phase: phase_q, tick: tick_q, bl: bl_q, alive: 1'b1};
    end
    s1      = s0;
    s1.tick = s0.tick - 1'b1;
    s2      = settle_f(s1, mode_d, cfg_i);
    if (!s0.alive) begin
      pstart_d = 1'b1;
      phase_d  = s0.phase;
      tick_d   = s0.tick;
      bl_d     = s0.bl;
    end else begin
      pstart_d = !s2.alive;
      phase_d  = s2.phase;
      tick_d   = s2.tick;
      bl_d     = s2.bl;
    end
    view_o.lit   = s0.alive && (s0.phase == ubcd_pkg::PH_LIT);
    view_o.count = count_d;
    view_o.mode  = mode_d;
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      mode_q   <= ubcd_pkg::MODE_UP;
      pstart_q <= 1'b1;
      phase_q  <= ubcd_pkg::PH_LIT;
      tick_q   <= '0;
      bl_q     <= '0;
    end else if (step_i) begin
      count_q  <= count_d;
      mode_q   <= mode_d;
      pstart_q <= pstart_d;
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      bl_q     <= bl_d;
    end
  end

endmodule

// ===== src/ubcd_disp.sv =====
// Display multiplexer: BCD split, segment decode, digit alternation and
// held segment pattern for dark ticks. Depends on ubcd_pkg.
module ubcd_disp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  ubcd_pkg::view_t               view_i,
  output logic [ubcd_pkg::SEG_W-1:0]    segments_o,
  output logic                          low_digit_on_o,
  output logic                          high_digit_on_o
);

  logic                       digit_sel_q;
  logic [ubcd_pkg::SEG_W-1:0] held_seg_q;
  logic [3:0]                 tens, units, digit;
  logic [ubcd_pkg::SEG_W-1:0] lit_seg;

  // BCD split; units = count - 10 * tens
  assign tens  = ubcd_pkg::tens_of(view_i.count);
  assign units = 4'(view_i.count - {tens, 3'b000} - {2'b00, tens, 1'b0});
  assign digit = digit_sel_q ? units : tens;
  assign lit_seg = ubcd_pkg::seg_code(digit);

  assign segments_o      = view_i.lit ? lit_seg : held_seg_q;
  assign low_digit_on_o  = view_i.lit && digit_sel_q;
  assign high_digit_on_o = view_i.lit && !digit_sel_q;

  // Digit select flips on lit ticks only; last pattern is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_sel_q <= 1'b0;
      held_seg_q  <= '0;
    end else if (step_i && view_i.lit) begin
      digit_sel_q <= !digit_sel_q;
      held_seg_q  <= lit_seg;
    end
  end

endmodule

// ===== src/updown_bcd_counter_display.sv =====
// Up/down BCD counter with multiplexed two-digit seven-segment display.
// Depends on ubcd_pkg, ubcd_if, ubcd_cfg_regs, ubcd_seq, ubcd_disp.
//
// Each input item is one display tick carrying the direction switch; each
// yields exactly one result item. The block takes one item per clock cycle
// unless stalled. An item goes through an input register, then one pass
// through the period sequencer and segment decode into the result register.
// The sequencer's next-state logic (phase skipping plus tick decrement)
// sets the cycle time. The result register is freed in the same cycle it is
// drained, so a stalled consumer only stops intake while both stages are
// full. Configuration registers reset to top 59, dwells 20/50, blinks 11/5,
// blanks 20/50 and tail 20, and should be written only while idle.
module updown_bcd_counter_display (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ubcd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ubcd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ubcd_in_if.sink                          in_i,
  ubcd_out_if.source                       out_o
);

  ubcd_pkg::cfg_t  cfg;
  ubcd_pkg::view_t view;

  logic in_valid_q;
  logic sw_q;
  logic out_valid_q;
  logic advance;

  logic [ubcd_pkg::SEG_W-1:0] seg;
  logic                       lo_on, hi_on;

  logic [ubcd_pkg::SEG_W-1:0] seg_q;
  logic                       lo_q, hi_q;
  logic [ubcd_pkg::CNT_W-1:0] cnt_q;
  logic [1:0]                 mode_q;

  // Item moves into the result register when that register is free
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  ubcd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ubcd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .switch_up_i (sw_q),
    .cfg_i       (cfg),
    .view_o      (view)
  );

  ubcd_disp u_disp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .view_i          (view),
    .segments_o      (seg),
    .low_digit_on_o  (lo_on),
    .high_digit_on_o (hi_on)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      sw_q <= in_i.switch_up;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      seg_q  <= seg;
      lo_q   <= lo_on;
      hi_q   <= hi_on;
      cnt_q  <= view.count;
      mode_q <= view.mode;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.segments      = seg_q;
  assign out_o.low_digit_on  = lo_q;
  assign out_o.high_digit_on = hi_q;
  assign out_o.count_value   = cnt_q;
  assign out_o.mode          = mode_q;

  // Only one digit is ever driven at a time
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(lo_q && hi_q))
    else $error("both digit enables high");

  // Counting modes always show a digit
  a_counting_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (mode_q == 2'(ubcd_pkg::MODE_UP) ||
                     mode_q == 2'(ubcd_pkg::MODE_DOWN))) |-> (lo_q || hi_q))
    else $error("counting tick shown dark");

  // Count stays within two BCD digits
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (cnt_q <= ubcd_pkg::COUNT_MAX))
    else $error("count above 99");

  // A processed item always lands in the result register
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost");

  // A waiting item is never dropped from the input register
  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(sw_q)))
    else $error("input item lost");

endmodule
